>>> rtl/ffia_pkg.sv
// Shared types and constants for the FIFO free-ID allocator.
package ffia_pkg;

  localparam int ID_W    = 10;              // identifier width, fixed by the ports
  localparam int MAX_IDS = 1 << ID_W;       // pool capacity
  localparam int CNT_W   = ID_W + 1;        // holds 0..MAX_IDS
  localparam int ADDR_W  = 1;               // APB byte address
  localparam int DATA_W  = 32;              // APB data

  typedef enum logic [1:0] {
    REQ_GET     = 2'd0,
    REQ_CHECK   = 2'd1,
    REQ_RELEASE = 2'd2
  } ffia_req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ffia_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic clear_en;   // clearing pass writes one entry this cycle
    logic load;       // item accepted: latch request, launch memory reads
    logic exec;       // execute state: update state, register the result
  } ffia_cmd_t;

endpackage

>>> rtl/fifo_free_id_allocator_unit.sv
// Top level of the FIFO free-ID allocator.
//
//  Channel   Ports                                          Handshake
//  --------  ---------------------------------------------  ------------------------
//  request   req_type, ident                                start && !busy
//  result    granted_id, granted, is_free, out_of_range     done, one cycle only
//  config    psel, penable, pwrite, paddr, pwdata, prdata   psel & penable & pwrite
//
// For each item the accept edge reads the free queue head and the free map
// entry, and the next edge updates queue, map, pointers and count and
// registers the result. done is high in the cycle after that, when busy is
// already low, so a new item may be started while the result is shown.
// After reset, and after each write of pool_size, a clearing pass over all 1024
// queue and map entries (one entry per cycle) keeps busy high; register
// writes are still taken and restart the pass. Results cannot be stalled.
module fifo_free_id_allocator_unit (
  input  logic                         clk,
  input  logic                         rst,
  // request
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type,
  input  logic [ffia_pkg::ID_W-1:0]    ident,
  // result
  output logic                         done,
  output logic [ffia_pkg::ID_W-1:0]    granted_id,
  output logic                         granted,
  output logic                         is_free,
  output logic                         out_of_range,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffia_pkg::ADDR_W-1:0]  paddr,
  input  logic [ffia_pkg::DATA_W-1:0]  pwdata,
  output logic [ffia_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  ffia_pkg::ffia_cmd_t         cmd;
  logic                        refill;
  logic                        clr_last;
  logic [ffia_pkg::CNT_W-1:0]  size_eff;

  // pool_size register; effective size saturates at capacity
  ffia_apb u_apb (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .refill   (refill),
    .size_eff (size_eff)
  );

  // sequencing: clearing pass, idle, execute
  ffia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .refill   (refill),
    .clr_last (clr_last),
    .busy     (busy),
    .cmd      (cmd)
  );

  // memories, pointers and result registers
  ffia_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .refill       (refill),
    .size_eff     (size_eff),
    .req_type     (req_type),
    .ident        (ident),
    .clr_last     (clr_last),
    .done         (done),
    .granted_id   (granted_id),
    .granted      (granted),
    .is_free      (is_free),
    .out_of_range (out_of_range)
  );

endmodule

>>> rtl/ffia_apb.sv
// APB register block holding pool_size; flags a refill on each write.
module ffia_apb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffia_pkg::ADDR_W-1:0]   paddr,
  input  logic [ffia_pkg::DATA_W-1:0]   pwdata,
  output logic [ffia_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic                          refill,
  output logic [ffia_pkg::CNT_W-1:0]    size_eff
);

  logic [ffia_pkg::CNT_W-1:0] pool_size;
  logic                       wr_en;

  // single register: every address decodes to it
  assign wr_en  = psel && penable && pwrite && (paddr == paddr);
  assign pready = 1'b1;
  assign refill = wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= ffia_pkg::CNT_W'(ffia_pkg::MAX_IDS);
    end else if (wr_en) begin
      pool_size <= pwdata[ffia_pkg::CNT_W-1:0];
    end
  end

  assign prdata   = ffia_pkg::DATA_W'(pool_size);
  // saturate to capacity
  assign size_eff = (pool_size > ffia_pkg::CNT_W'(ffia_pkg::MAX_IDS)) ?
                    ffia_pkg::CNT_W'(ffia_pkg::MAX_IDS) : pool_size;

endmodule

>>> rtl/ffia_ctrl.sv
// Controller state machine: clearing pass, idle, execute.
module ffia_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                refill,
  input  logic                clr_last,
  output logic                busy,
  output ffia_pkg::ffia_cmd_t cmd
);

  ffia_pkg::ffia_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffia_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ffia_pkg::ST_CLEAR: begin
        if (refill) state_next = ffia_pkg::ST_CLEAR;
        else if (clr_last) state_next = ffia_pkg::ST_IDLE;
      end
      ffia_pkg::ST_IDLE: begin
        if (refill) state_next = ffia_pkg::ST_CLEAR;
        else if (start) state_next = ffia_pkg::ST_EXEC;
      end
      ffia_pkg::ST_EXEC: begin
        if (refill) state_next = ffia_pkg::ST_CLEAR;
        else state_next = ffia_pkg::ST_IDLE;
      end
      default: state_next = ffia_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    cmd.clear_en = 1'b0;
    cmd.load     = 1'b0;
    cmd.exec     = 1'b0;
    case (state)
      ffia_pkg::ST_CLEAR: begin
        cmd.clear_en = !refill;
      end
      ffia_pkg::ST_IDLE: begin
        busy     = refill;
        cmd.load = start && !refill;
      end
      ffia_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/ffia_datapath.sv
// Datapath: free queue and free map memories, pointers, count, result regs.
module ffia_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  ffia_pkg::ffia_cmd_t          cmd,
  input  logic                         refill,
  input  logic [ffia_pkg::CNT_W-1:0]   size_eff,
  input  logic [1:0]                   req_type,
  input  logic [ffia_pkg::ID_W-1:0]    ident,
  output logic                         clr_last,
  output logic                         done,
  output logic [ffia_pkg::ID_W-1:0]    granted_id,
  output logic                         granted,
  output logic                         is_free,
  output logic                         out_of_range
);

  localparam logic [ffia_pkg::CNT_W-1:0] CAP = ffia_pkg::CNT_W'(ffia_pkg::MAX_IDS);

  logic [ffia_pkg::ID_W-1:0] free_queue [ffia_pkg::MAX_IDS];
  logic                      free_map   [ffia_pkg::MAX_IDS];

  logic [ffia_pkg::ID_W-1:0]  queue_head;
  logic [ffia_pkg::ID_W-1:0]  queue_tail;
  logic [ffia_pkg::CNT_W-1:0] free_count;
  logic [ffia_pkg::ID_W-1:0]  clr_idx;

  logic [1:0]                req_r;
  logic [ffia_pkg::ID_W-1:0] ident_r;
  logic [ffia_pkg::ID_W-1:0] q_rd;
  logic                      m_rd;

  logic oor;
  logic get_ok;
  logic rel_ok;
  logic clr_val;

  assign clr_last = (clr_idx == {ffia_pkg::ID_W{1'b1}});
  assign clr_val  = ({1'b0, clr_idx} < size_eff);

  assign oor    = ({1'b0, ident_r} >= size_eff);
  assign get_ok = (req_r == ffia_pkg::REQ_GET) && (free_count != '0);
  assign rel_ok = (req_r == ffia_pkg::REQ_RELEASE) && !oor && !m_rd &&
                  (free_count < CAP);

  // free queue: clearing pass loads 0..MAX-1, release writes at the tail
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      free_queue[clr_idx] <= clr_idx;
    end else if (cmd.exec && rel_ok) begin
      free_queue[queue_tail] <= ident_r;
    end
    if (cmd.load) begin
      q_rd <= free_queue[queue_head];
    end
  end

  // free map: pass marks ids below the size, get clears, release sets
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      free_map[clr_idx] <= clr_val;
    end else if (cmd.exec && get_ok) begin
      free_map[q_rd] <= 1'b0;
    end else if (cmd.exec && rel_ok) begin
      free_map[ident_r] <= 1'b1;
    end
    if (cmd.load) begin
      m_rd <= free_map[ident];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= req_type;
      ident_r <= ident;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      queue_head <= '0;
      queue_tail <= '0;
      free_count <= '0;
    end else if (refill) begin
      clr_idx <= '0;
    end else if (cmd.clear_en) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_last) begin
        queue_head <= '0;
        queue_tail <= size_eff[ffia_pkg::ID_W-1:0];
        free_count <= size_eff;
      end
    end else if (cmd.exec) begin
      if (get_ok) begin
        queue_head <= queue_head + 1'b1;
        free_count <= free_count - 1'b1;
      end else if (rel_ok) begin
        queue_tail <= queue_tail + 1'b1;
        free_count <= free_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      granted_id   <= get_ok ? q_rd : '0;
      granted      <= get_ok;
      is_free      <= (req_r == ffia_pkg::REQ_CHECK) && !oor && m_rd;
      out_of_range <= ((req_r == ffia_pkg::REQ_CHECK) ||
                       (req_r == ffia_pkg::REQ_RELEASE)) && oor;
    end
  end

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the FIFO free-ID allocator: directed and random requests.
module tb_top;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  // A result is registered by the execute step after its accept edge; the spare cycles cover it.
  localparam int DRAIN_CYCLES = 4;
  // Slowest run: about a dozen clearing passes plus some 1350 items with long
  // sender gaps stays well under the limit.
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int MAX_REPORTS  = 10;
  localparam logic [ffia_pkg::ADDR_W-1:0] POOL_SIZE_ADDR = '0;

  // One result item, in port order.
  typedef struct packed {
    logic [ffia_pkg::ID_W-1:0] gid;
    logic                      granted;
    logic                      is_free;
    logic                      oor;
  } alloc_result_t;

  // One pending request. from_held asks the driver to swap in an identifier
  // that is handed out at the moment the request goes on the ports.
  typedef struct {
    ffia_pkg::ffia_req_t       req;
    logic [ffia_pkg::ID_W-1:0] ident;
    bit                        from_held;
  } id_request_t;

  // Every input starts from a known value.
  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        start    = 1'b0;
  logic [1:0]                  req_type = '0;
  logic [ffia_pkg::ID_W-1:0]   ident    = '0;
  logic                        psel     = 1'b0;
  logic                        penable  = 1'b0;
  logic                        pwrite   = 1'b0;
  logic [ffia_pkg::ADDR_W-1:0] paddr    = '0;
  logic [ffia_pkg::DATA_W-1:0] pwdata   = '0;

  logic                        busy;
  logic                        done;
  logic [ffia_pkg::ID_W-1:0]   granted_id;
  logic                        granted;
  logic                        is_free;
  logic                        out_of_range;
  logic [ffia_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  id_request_t   request_backlog[$];
  alloc_result_t expected_replies[$];

  int unsigned items_queued = 0;
  int unsigned replies_seen = 0;
  int unsigned fault_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned sender_idle_pct = 0;

  // Shadow of the allocator: free FIFO, free flags, pointers and count.
  logic [ffia_pkg::ID_W-1:0]  free_fifo [ffia_pkg::MAX_IDS];
  bit                         free_flag [ffia_pkg::MAX_IDS];
  int                         fifo_head;
  int                         fifo_tail;
  int                         free_total;
  logic [ffia_pkg::CNT_W-1:0] pool_size_cfg;

  fifo_free_id_allocator_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .ident        (ident),
    .done         (done),
    .granted_id   (granted_id),
    .granted      (granted),
    .is_free      (is_free),
    .out_of_range (out_of_range),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Effective pool size: the register saturates at the pool capacity.
  function automatic int pool_limit();
    return (int'(pool_size_cfg) > ffia_pkg::MAX_IDS) ? ffia_pkg::MAX_IDS
                                                     : int'(pool_size_cfg);
  endfunction

  // Reload the shadow FIFO with 0..S-1 and mark exactly those free.
  function automatic void refill_pool();
    int s;
    s = pool_limit();
    for (int i = 0; i < ffia_pkg::MAX_IDS; i++) begin
      free_fifo[i] = (i < s) ? ffia_pkg::ID_W'(i) : '0;
      free_flag[i] = (i < s);
    end
    fifo_head  = 0;
    fifo_tail  = (s >= ffia_pkg::MAX_IDS) ? 0 : s;
    free_total = s;
  endfunction

  // Apply one accepted request to the shadow and return the result it gives.
  function automatic alloc_result_t serve_request(input ffia_pkg::ffia_req_t rq,
                                                  input logic [ffia_pkg::ID_W-1:0] id);
    alloc_result_t r;
    int s;
    r = '0;
    s = pool_limit();
    case (rq)
      ffia_pkg::REQ_GET: begin
        // an empty pool leaves everything untouched and answers all zeros
        if (free_total != 0) begin
          r.gid             = free_fifo[fifo_head];
          r.granted         = 1'b1;
          free_flag[r.gid]  = 1'b0;
          fifo_head         = (fifo_head + 1) % ffia_pkg::MAX_IDS;
          free_total--;
        end
      end
      ffia_pkg::REQ_CHECK: begin
        if (int'(id) >= s) r.oor = 1'b1;
        else r.is_free = free_flag[id];
      end
      ffia_pkg::REQ_RELEASE: begin
        // out of range is flagged and dropped; an already free id is dropped quietly
        if (int'(id) >= s) begin
          r.oor = 1'b1;
        end else if (!free_flag[id] && free_total < ffia_pkg::MAX_IDS) begin
          free_fifo[fifo_tail] = id;
          fifo_tail            = (fifo_tail + 1) % ffia_pkg::MAX_IDS;
          free_flag[id]        = 1'b1;
          free_total++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Pick one in-range identifier that is currently handed out, if any.
  function automatic logic [ffia_pkg::ID_W-1:0] pick_held_id(
      input logic [ffia_pkg::ID_W-1:0] fallback);
    int s;
    int held;
    int k;
    s    = pool_limit();
    held = 0;
    for (int i = 0; i < s; i++)
      if (!free_flag[i]) held++;
    if (held == 0) return fallback;
    k = $urandom_range(held - 1);
    for (int i = 0; i < s; i++) begin
      if (!free_flag[i]) begin
        if (k == 0) return ffia_pkg::ID_W'(i);
        k--;
      end
    end
    return fallback;
  endfunction

  // Driver: prediction happens at the accept edge, so the shadow always
  // matches what the block has seen; the next item is loaded in the same step.
  always @(posedge clk) begin : drive_requests
    id_request_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_replies.push_back(serve_request(ffia_pkg::ffia_req_t'(req_type), ident));
      end
      // a request still waiting on busy is held as it stands
      if (!start || !busy) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = request_backlog.pop_front();
          if (nxt.from_held) nxt.ident = pick_held_id(nxt.ident);
          start    <= 1'b1;
          req_type <= nxt.req;
          ident    <= nxt.ident;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done strobe is one result item, checked against the oldest
  // prediction.
  always @(posedge clk) begin : check_replies
    alloc_result_t want;
    alloc_result_t got;
    if (!rst && done) begin
      got = {granted_id, granted, is_free, out_of_range};
      replies_seen++;
      if (expected_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("result with none pending: id=%0d granted=%0b free=%0b oor=%0b",
                   got.gid, got.granted, got.is_free, got.oor);
      end else begin
        want = expected_replies.pop_front();
        if (got.gid !== want.gid || got.granted !== want.granted ||
            got.is_free !== want.is_free || got.oor !== want.oor) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display({"mismatch at %0t: exp id=%0d gr=%0b free=%0b oor=%0b,",
                      " got id=%0d gr=%0b free=%0b oor=%0b"},
                     $realtime, want.gid, want.granted, want.is_free, want.oor,
                     got.gid, got.granted, got.is_free, got.oor);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_item(input ffia_pkg::ffia_req_t rq,
                          input logic [ffia_pkg::ID_W-1:0] id,
                          input bit held);
    id_request_t it;
    it.req       = rq;
    it.ident     = id;
    it.from_held = held;
    request_backlog.push_back(it);
    items_queued++;
  endtask

  // Block until every queued item has produced its result, then let the
  // pipeline settle.
  task automatic wait_drained();
    while (replies_seen < items_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup and access phase; the register takes the value at the access edge,
  // where the shadow is reloaded as well.
  task automatic write_pool_size(input int unsigned val);
    while (busy) @(posedge clk);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= POOL_SIZE_ADDR;
    pwdata  <= ffia_pkg::DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pool_size_cfg = ffia_pkg::CNT_W'(val);
    refill_pool();
  endtask

  // Random mix sized to the current pool: gets, checks and releases, with
  // 55 percent of the releases aimed at identifiers that are really out.
  task automatic queue_random(input int n);
    int s;
    int r;
    int pick;
    ffia_pkg::ffia_req_t rq;
    logic [ffia_pkg::ID_W-1:0] id;
    bit held;
    s = pool_limit();
    for (int i = 0; i < n; i++) begin
      r    = $urandom_range(99);
      rq   = (r < 40) ? ffia_pkg::REQ_GET :
             (r < 65) ? ffia_pkg::REQ_CHECK : ffia_pkg::REQ_RELEASE;
      held = (rq == ffia_pkg::REQ_RELEASE) && ($urandom_range(99) < 55);
      pick = $urandom_range(99);
      if (pick < 50) begin
        id = ffia_pkg::ID_W'($urandom_range(s - 1));
      end else if (pick < 75) begin
        // the pool edges and the ends of the identifier range
        case ($urandom_range(3))
          0: id = '0;
          1: id = ffia_pkg::ID_W'(s - 1);
          2: id = ffia_pkg::ID_W'(s);
          default: id = '1;
        endcase
      end else begin
        id = ffia_pkg::ID_W'($urandom);
      end
      add_item(rq, id, held);
    end
  endtask

  task automatic run_phase(input int unsigned size, input int n);
    wait_drained();
    write_pool_size(size);
    queue_random(n);
  endtask

  initial begin : stimulus
    pool_size_cfg = ffia_pkg::CNT_W'(ffia_pkg::MAX_IDS);
    refill_pool();
    sender_idle_pct = 30;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset pool of 1024: first grant, top id, duplicate release.
    add_item(ffia_pkg::REQ_GET,     '0,                 1'b0);
    add_item(ffia_pkg::REQ_CHECK,   '0,                 1'b0);
    add_item(ffia_pkg::REQ_CHECK,   '1,                 1'b0);
    add_item(ffia_pkg::REQ_RELEASE, '1,                 1'b0);   // already free
    add_item(ffia_pkg::REQ_RELEASE, '0,                 1'b0);
    add_item(ffia_pkg::REQ_CHECK,   '0,                 1'b0);

    // Smallest pool: empty on second get, out of range above it.
    wait_drained();
    write_pool_size(1);
    add_item(ffia_pkg::REQ_GET,     '0,                 1'b0);
    add_item(ffia_pkg::REQ_GET,     '1,                 1'b0);   // pool empty
    add_item(ffia_pkg::REQ_CHECK,   '0,                 1'b0);
    add_item(ffia_pkg::REQ_CHECK,   ffia_pkg::ID_W'(1), 1'b0);   // just out of range
    add_item(ffia_pkg::REQ_RELEASE, '1,                 1'b0);
    add_item(ffia_pkg::REQ_RELEASE, '0,                 1'b0);
    add_item(ffia_pkg::REQ_CHECK,   '0,                 1'b0);
    add_item(ffia_pkg::REQ_GET,     '0,                 1'b0);

    // Three ids: released ones come back in release order.
    wait_drained();
    write_pool_size(3);
    add_item(ffia_pkg::REQ_GET,     '0,                 1'b0);
    add_item(ffia_pkg::REQ_GET,     '0,                 1'b0);
    add_item(ffia_pkg::REQ_GET,     '0,                 1'b0);
    add_item(ffia_pkg::REQ_GET,     '0,                 1'b0);   // empty
    add_item(ffia_pkg::REQ_RELEASE, ffia_pkg::ID_W'(2), 1'b0);
    add_item(ffia_pkg::REQ_RELEASE, '0,                 1'b0);
    add_item(ffia_pkg::REQ_RELEASE, ffia_pkg::ID_W'(2), 1'b0);   // duplicate, dropped
    add_item(ffia_pkg::REQ_GET,     '0,                 1'b0);
    add_item(ffia_pkg::REQ_GET,     '0,                 1'b0);
    add_item(ffia_pkg::REQ_CHECK,   ffia_pkg::ID_W'(2), 1'b0);

    // Sender idles now and then at first.
    run_phase(ffia_pkg::MAX_IDS, 150);
    run_phase(2, 120);
    // Tail pointer starts near the top; forty releases push it round the wrap.
    wait_drained();
    write_pool_size(1000);
    repeat (40) add_item(ffia_pkg::REQ_GET, '0, 1'b0);
    repeat (40) add_item(ffia_pkg::REQ_RELEASE, '0, 1'b1);
    queue_random(100);

    wait_drained();
    sender_idle_pct = 73;
    run_phase(1, 100);
    run_phase(ffia_pkg::MAX_IDS, 130);
    run_phase(9, 150);

    // Back-to-back items.
    wait_drained();
    sender_idle_pct = 0;
    run_phase(3, 150);
    run_phase(64, 200);
    run_phase(ffia_pkg::MAX_IDS, 120);

    wait_drained();
    fault_count += expected_replies.size();
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
